FILE: hdl/mcd_pkg.sv
`timescale 1ns / 1ps

package mcd_pkg;

    // Input action codes carried on the slave tuser
    typedef enum logic [1:0] {
        ACT_FAST_TICK   = 2'd0,
        ACT_SECOND_TICK = 2'd1,
        ACT_BUTTON_POLL = 2'd2,
        ACT_UNUSED      = 2'd3
    } t_action;

    // Configuration register indexes
    localparam logic REG_START_COUNT   = 1'b0;
    localparam logic REG_LOCKOUT_TICKS = 1'b1;

    // Reset values of the configuration registers
    localparam logic [7:0] START_COUNT_RST   = 8'd100;
    localparam logic [9:0] LOCKOUT_TICKS_RST = 10'd300;

    // Phase thresholds of the four-phase digit cycle
    localparam logic [2:0] PHASE_LIT   = 3'd2;
    localparam logic [2:0] PHASE_SWAP  = 3'd4;

    // Result transaction, packed so the first field lands in the highest bits
    typedef struct packed {
        logic [7:0] count_now;
        logic [3:0] cathode_code;
        logic       anode_ones;
        logic       anode_tens;
    } t_result;

    localparam int RESULT_W = $bits(t_result);
    localparam int TDATA_W  = 16;

    // Tens digit of (value mod 100): strip hundreds, then divide by ten
    // through the reciprocal 205 / 2048, exact for values below 1029
    function automatic logic [3:0] tens_digit(input logic [7:0] value);
        logic [6:0]  below_hundred;
        logic [14:0] scaled;
        begin
            if (value >= 8'd200) begin
                below_hundred = 7'(value - 8'd200);
            end else if (value >= 8'd100) begin
                below_hundred = 7'(value - 8'd100);
            end else begin
                below_hundred = value[6:0];
            end
            scaled = 15'(below_hundred) * 15'd205;
            tens_digit = scaled[14:11];
        end
    endfunction

    // Ones digit: value minus ten times its quotient by ten
    function automatic logic [3:0] ones_digit(input logic [7:0] value);
        logic [15:0] scaled;
        logic [4:0]  quotient;
        logic [7:0]  tens_part;
        begin
            scaled    = 16'(value) * 16'd205;
            quotient  = scaled[15:11];
            tens_part = 8'(quotient) * 8'd10;
            ones_digit = 4'(value - tens_part);
        end
    endfunction

endpackage

FILE: hdl/multiplexed_countdown_display.sv
`timescale 1ns / 1ps
// Channel  | Signals                              | Contents
// ---------+--------------------------------------+--------------------------------------
// input    | i_s_axis_tvalid/o_s_axis_tready      | tuser: action; tdata: button_pressed
// result   | o_m_axis_tvalid/i_m_axis_tready      | tdata: anode_tens, anode_ones,
//          |                                      |        cathode_code, count_now
// config   | i_cfg_we, i_cfg_addr, i_cfg_wdata    | 0 start_count, 1 lockout_ticks
//
// One transaction per clock while the skid entry is empty: the state update is a single
// short pass from the state registers to the result register, so an item can enter
// every cycle until a stall fills the skid entry. Each result is registered there.
// Synchronous active-low reset clears all state; configuration returns to 100/300.
// A stalled result parks in a one-entry skid stage; input is refused only when
// both the output register and the skid entry are full.

module multiplexed_countdown_display (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input transactions
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,  // [0] button_pressed, [7:1] zero
    input  logic [1:0]  i_s_axis_tuser,  // [1:0] action
    // Result transactions
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,  // [0] anode_tens, [1] anode_ones,
                                         // [5:2] cathode_code, [13:6] count_now,
                                         // [15:14] zero
    // Configuration writes
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [9:0]  i_cfg_wdata
);

    logic [7:0]       r_start_count;
    logic [9:0]       r_lockout_ticks;
    logic             in_accept;
    mcd_pkg::t_result core_result;
    mcd_pkg::t_result out_result;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_count   <= mcd_pkg::START_COUNT_RST;
            r_lockout_ticks <= mcd_pkg::LOCKOUT_TICKS_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == mcd_pkg::REG_START_COUNT) begin
                r_start_count <= i_cfg_wdata[7:0];
            end else begin
                r_lockout_ticks <= i_cfg_wdata;
            end
        end
    end

    assign in_accept = i_s_axis_tvalid && o_s_axis_tready;

    mcd_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (in_accept),
        .i_action         (i_s_axis_tuser),
        .i_button_pressed (i_s_axis_tdata[0]),
        .i_start_count    (r_start_count),
        .i_lockout_ticks  (r_lockout_ticks),
        .o_result         (core_result)
    );

    mcd_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (in_accept),
        .i_result (core_result),
        .o_ready  (o_s_axis_tready),
        .o_valid  (o_m_axis_tvalid),
        .o_result (out_result),
        .i_ready  (i_m_axis_tready)
    );

    assign o_m_axis_tdata = {(mcd_pkg::TDATA_W - mcd_pkg::RESULT_W)'(0), out_result};

endmodule

FILE: hdl/mcd_core.sv
`timescale 1ns / 1ps

module mcd_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [1:0]        i_action,
    input  logic              i_button_pressed,
    input  logic [7:0]        i_start_count,
    input  logic [9:0]        i_lockout_ticks,
    output mcd_pkg::t_result  o_result
);

    logic [7:0] r_countdown, n_countdown;
    logic [9:0] r_lockout_left, n_lockout_left;
    logic       r_digit_select, n_digit_select;
    logic [2:0] r_phase_count, n_phase_count;
    logic       r_anode_tens, n_anode_tens;
    logic       r_anode_ones, n_anode_ones;
    logic [3:0] r_cathode, n_cathode;

    logic [2:0] phase_inc;
    logic [3:0] digit_code;

    assign phase_inc  = r_phase_count + 3'd1;
    assign digit_code = r_digit_select ? mcd_pkg::ones_digit(r_countdown)
                                       : mcd_pkg::tens_digit(r_countdown);

    // Work out the next state for one action
    always_comb begin
        n_countdown    = r_countdown;
        n_lockout_left = r_lockout_left;
        n_digit_select = r_digit_select;
        n_phase_count  = r_phase_count;
        n_anode_tens   = r_anode_tens;
        n_anode_ones   = r_anode_ones;
        n_cathode      = r_cathode;
        case (mcd_pkg::t_action'(i_action))
            mcd_pkg::ACT_FAST_TICK: begin
                if (r_lockout_left != 10'd0) begin
                    n_lockout_left = r_lockout_left - 10'd1;
                end
                if (phase_inc < mcd_pkg::PHASE_SWAP) begin
                    n_phase_count = phase_inc;
                    n_cathode     = digit_code;
                    n_anode_tens  = !r_digit_select && (phase_inc >= mcd_pkg::PHASE_LIT);
                    n_anode_ones  = r_digit_select && (phase_inc >= mcd_pkg::PHASE_LIT);
                end else begin
                    // Swap digits and hold the pins
                    n_digit_select = !r_digit_select;
                    n_phase_count  = 3'd0;
                end
            end
            mcd_pkg::ACT_SECOND_TICK: begin
                if (r_countdown != 8'd0) begin
                    n_countdown = r_countdown - 8'd1;
                end
            end
            mcd_pkg::ACT_BUTTON_POLL: begin
                if (r_lockout_left == 10'd0 && i_button_pressed) begin
                    n_countdown    = i_start_count;
                    n_lockout_left = i_lockout_ticks;
                end
            end
            default: begin
            end
        endcase
    end

    // Advance the state on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_countdown    <= 8'd0;
            r_lockout_left <= 10'd0;
            r_digit_select <= 1'b0;
            r_phase_count  <= 3'd0;
            r_anode_tens   <= 1'b0;
            r_anode_ones   <= 1'b0;
            r_cathode      <= 4'd0;
        end else if (i_accept) begin
            r_countdown    <= n_countdown;
            r_lockout_left <= n_lockout_left;
            r_digit_select <= n_digit_select;
            r_phase_count  <= n_phase_count;
            r_anode_tens   <= n_anode_tens;
            r_anode_ones   <= n_anode_ones;
            r_cathode      <= n_cathode;
        end
    end

    assign o_result.count_now    = n_countdown;
    assign o_result.cathode_code = n_cathode;
    assign o_result.anode_ones   = n_anode_ones;
    assign o_result.anode_tens   = n_anode_tens;

endmodule

FILE: hdl/mcd_out_buf.sv
`timescale 1ns / 1ps

module mcd_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  mcd_pkg::t_result  i_result,
    output logic              o_ready,
    output logic              o_valid,
    output mcd_pkg::t_result  o_result,
    input  logic              i_ready
);

    logic             r_out_valid;
    logic             r_skid_valid;
    mcd_pkg::t_result r_out;
    mcd_pkg::t_result r_skid;

    assign o_ready  = !r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // Output register with one skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out       <= i_result;
                r_out_valid <= i_valid;
            end
        end else if (i_valid && !r_skid_valid) begin
            r_skid       <= i_result;
            r_skid_valid <= 1'b1;
        end
    end

endmodule
